@@ rtl/zero_crossing_chunk_pitch_squeezer_top_assert.svh @@
// Assertion macros for the chunk pitch squeezer top level.
// Used by zero_crossing_chunk_pitch_squeezer_top.sv; expects clk and arst_n in scope.
`ifndef ZERO_CROSSING_CHUNK_PITCH_SQUEEZER_TOP_ASSERT_SVH
`define ZERO_CROSSING_CHUNK_PITCH_SQUEEZER_TOP_ASSERT_SVH

// The condition must never be seen at a clock edge outside reset.
`define ZCCPS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define ZCCPS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/zccps_pkg.sv @@
// Shared types and constants for the chunk pitch squeezer.
// Used by every module of the block; depends on nothing.
package zccps_pkg;

	// Configuration register widths and reset values.
	localparam int LEN_CFG_W   = 13;
	localparam int RATIO_CFG_W = 21;
	localparam int CROSS_CFG_W = 8;
	localparam int CFG_DATA_W  = 21;
	localparam int CFG_INDEX_W = 2;

	localparam logic [LEN_CFG_W-1:0]   LEN_RESET   = 13'd4096;
	localparam logic [RATIO_CFG_W-1:0] RATIO_RESET = 21'd512;
	localparam logic [CROSS_CFG_W-1:0] CROSS_RESET = 8'd1;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BUFFER_LENGTH = 2'd0,
		REG_PITCH_RATIO   = 2'd1,
		REG_CROSSINGS     = 2'd2
	} cfg_reg_t;

	// Output queue geometry.
	localparam int               OUTQ_LEVEL_W = 2;
	localparam logic [1:0]       OUTQ_LAST    = 2'd2;
	localparam logic [1:0]       OUTQ_FULL    = 2'd3;

	// Status of the item whose store read is in flight.
	typedef struct packed {
		logic valid;
		logic hit;
	} rd_stat_t;

endpackage

@@ rtl/zero_crossing_chunk_pitch_squeezer_top.sv @@
// Channel | Handshake           | Payload
// input   | in_valid, in_stall  | sample_in
// output  | out_valid, out_stall| sample_out
// config  | cfg_valid, cfg_ready| cfg_index, cfg_data
//
// One item per cycle while in_stall is low; the store read and the output queue are both registered.
// The store has one write port and one read port, and each item uses each once.
// Reset needs no clearing pass: a fill mark tells which entries still read as zero.
// in_stall rises when the output queue and the read in flight hold three items.
// Depends on zccps_pkg, zccps_ctrl, zccps_store, zccps_outq and the assertion header.
`include "zero_crossing_chunk_pitch_squeezer_top_assert.svh"
module zero_crossing_chunk_pitch_squeezer_top import zccps_pkg::*; #(
	parameter int MAX_BUFFER_LENGTH = 4096,
	parameter int SAMPLE_BITS       = 24,
	parameter int FRACTION_BITS     = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] sample_out,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = (MAX_BUFFER_LENGTH > 1) ? $clog2(MAX_BUFFER_LENGTH) : 1;

	logic [LEN_CFG_W-1:0]    len_q;
	logic [RATIO_CFG_W-1:0]  ratio_q;
	logic [CROSS_CFG_W-1:0]  cross_q;
	logic                    take;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic [SAMPLE_BITS-1:0]  rd_data;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [SAMPLE_BITS-1:0]  wr_data;
	rd_stat_t                stat_s1;
	logic [OUTQ_LEVEL_W-1:0] level;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_RESET;
			ratio_q <= RATIO_RESET;
			cross_q <= CROSS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BUFFER_LENGTH: begin
					len_q <= cfg_data[LEN_CFG_W-1:0];
				end
				REG_PITCH_RATIO: begin
					ratio_q <= cfg_data[RATIO_CFG_W-1:0];
				end
				REG_CROSSINGS: begin
					cross_q <= cfg_data[CROSS_CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Input flow control: room for the item in flight plus the queued results.
	assign in_stall = ({1'b0, level} + (OUTQ_LEVEL_W + 1)'(stat_s1.valid))
		>= (OUTQ_LEVEL_W + 1)'(OUTQ_FULL);
	assign take = in_valid & ~in_stall;

	zccps_ctrl #(
		.MAX_BUFFER_LENGTH(MAX_BUFFER_LENGTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.sample_in(sample_in),
		.len_cfg(len_q),
		.ratio_cfg(ratio_q),
		.cross_cfg(cross_q),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.stat_s1(stat_s1)
	);

	zccps_store #(
		.DEPTH(MAX_BUFFER_LENGTH),
		.AW(AW),
		.DW(SAMPLE_BITS)
	) u_store (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	zccps_outq #(
		.DW(SAMPLE_BITS)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.stat_s1(stat_s1),
		.rd_data(rd_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.level(level)
	);

	// The queue never receives a read result while it is full.
	`ZCCPS_NEVER(a_queue_no_overflow, (level == OUTQ_FULL) && stat_s1.valid, "output queue overflow")
	// Every accepted item has its store read in flight in the next cycle.
	`ZCCPS_NEXT(a_take_reads, in_valid && !in_stall, stat_s1.valid, "accepted item lost")
	// No read result appears without an accepted item.
	`ZCCPS_NEXT(a_no_phantom, !(in_valid && !in_stall), !stat_s1.valid, "read without item")

endmodule

@@ rtl/zccps_store.sv @@
// Chunk store: one write port and one registered read port.
// Imports zccps_pkg; the read returns the contents from before a same-cycle write.
module zccps_store import zccps_pkg::*; #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// Read first, then write, so a read of the entry being written sees the old word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/zccps_ctrl.sv @@
// Chunk control: read position, write index, crossing count and fill mark.
// Uses zccps_pkg; drives the ports of zccps_store.
module zccps_ctrl import zccps_pkg::*; #(
	parameter int MAX_BUFFER_LENGTH = 4096,
	parameter int SAMPLE_BITS       = 24,
	parameter int FRACTION_BITS     = 8,
	parameter int AW                = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	input  logic [LEN_CFG_W-1:0]   len_cfg,
	input  logic [RATIO_CFG_W-1:0] ratio_cfg,
	input  logic [CROSS_CFG_W-1:0] cross_cfg,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [SAMPLE_BITS-1:0] wr_data,
	output rd_stat_t               stat_s1
);

	localparam int LW  = AW + 1;
	localparam int RPW = AW + FRACTION_BITS + 1;
	localparam int CLW = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
	localparam int RCW = (RPW > RATIO_CFG_W) ? RPW : RATIO_CFG_W;
	localparam logic [CLW-1:0] LEN_MIN   = CLW'(2);
	localparam logic [CLW-1:0] LEN_MAX   = CLW'(MAX_BUFFER_LENGTH);
	localparam logic [RCW-1:0] RATIO_ONE = RCW'(1) << FRACTION_BITS;

	logic [RPW-1:0]         rp_q;
	logic [AW-1:0]          wi_q;
	logic [AW-1:0]          hw_q;
	logic                   zero_wr_q;
	logic [CROSS_CFG_W-1:0] cc_q;
	logic                   prev_neg_q;

	logic [CLW-1:0]         len_ext;
	logic [CLW-1:0]         len_clamp;
	logic [LW-1:0]          len;
	logic [RCW-1:0]         ratio_ext;
	logic [RCW-1:0]         ratio_max;
	logic [RCW-1:0]         ratio_clamp;
	logic [RPW-1:0]         ratio;
	logic [LW-1:0]          ridx;
	logic                   in_range;
	logic                   entry_written;
	logic [RPW-1:0]         rp_sum;
	logic [LW-1:0]          wi_next;
	logic                   wrap;
	logic                   crossing;
	logic [CROSS_CFG_W-1:0] cc_inc;
	logic                   new_chunk;
	logic [AW-1:0]          wr_idx;

	// Active length and read increment, both clamped.
	always_comb begin
		len_ext = CLW'(len_cfg);
		if (len_ext < LEN_MIN) begin
			len_clamp = LEN_MIN;
		end else if (len_ext > LEN_MAX) begin
			len_clamp = LEN_MAX;
		end else begin
			len_clamp = len_ext;
		end
		len = len_clamp[LW-1:0];

		ratio_ext = RCW'(ratio_cfg);
		ratio_max = RCW'(len) << FRACTION_BITS;
		if (ratio_ext < RATIO_ONE) begin
			ratio_clamp = RATIO_ONE;
		end else if (ratio_ext > ratio_max) begin
			ratio_clamp = ratio_max;
		end else begin
			ratio_clamp = ratio_ext;
		end
		ratio = ratio_clamp[RPW-1:0];
	end

	// Read side: index from the integer part of the position. Entries above the
	// fill mark, and entry zero before the first new chunk, still hold zero.
	always_comb begin
		ridx     = rp_q[RPW-1:FRACTION_BITS];
		in_range = ridx < len;
		if (ridx[AW-1:0] == '0) begin
			entry_written = zero_wr_q;
		end else begin
			entry_written = ridx[AW-1:0] <= hw_q;
		end
		rp_sum = rp_q + ratio;
	end

	// Write side: advance, then test for the end of the chunk.
	always_comb begin
		wi_next   = LW'(wi_q) + LW'(1);
		wrap      = wi_next >= len;
		crossing  = prev_neg_q & ~sample_in[SAMPLE_BITS-1];
		cc_inc    = cc_q + CROSS_CFG_W'(1);
		new_chunk = wrap || (crossing && (cc_inc >= cross_cfg));
		wr_idx    = new_chunk ? '0 : wi_next[AW-1:0];
	end

	assign rd_en   = take;
	assign rd_addr = ridx[AW-1:0];
	assign wr_en   = take;
	assign wr_addr = wr_idx;
	assign wr_data = sample_in;

	// State update on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q       <= '0;
			wi_q       <= '0;
			hw_q       <= '0;
			zero_wr_q  <= 1'b0;
			cc_q       <= '0;
			prev_neg_q <= 1'b0;
			stat_s1    <= '0;
		end else begin
			stat_s1.valid <= take;
			stat_s1.hit   <= take & in_range & entry_written;
			if (take) begin
				prev_neg_q <= sample_in[SAMPLE_BITS-1];
				wi_q       <= wr_idx;
				if (new_chunk) begin
					rp_q      <= '0;
					cc_q      <= '0;
					zero_wr_q <= 1'b1;
				end else begin
					if (in_range) begin
						rp_q <= rp_sum;
					end
					if (crossing) begin
						cc_q <= cc_inc;
					end
					if (wi_next[AW-1:0] > hw_q) begin
						hw_q <= wi_next[AW-1:0];
					end
				end
			end
		end
	end

endmodule

@@ rtl/zccps_outq.sv @@
// Three-entry output queue that takes store read data and presents results.
// Uses zccps_pkg for the read status struct and queue constants.
module zccps_outq import zccps_pkg::*; #(
	parameter int DW = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rd_stat_t                stat_s1,
	input  logic [DW-1:0]           rd_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DW-1:0]           sample_out,
	output logic [OUTQ_LEVEL_W-1:0] level
);

	logic [DW-1:0]           data_q [3];
	logic [1:0]              head_q;
	logic [1:0]              tail_q;
	logic [OUTQ_LEVEL_W-1:0] level_q;
	logic                    push;
	logic                    pop;
	logic [DW-1:0]           push_data;

	// A miss or an out-of-range read gives a zero sample.
	assign push      = stat_s1.valid;
	assign push_data = stat_s1.hit ? rd_data : '0;
	assign out_valid = level_q != '0;
	assign pop       = out_valid & ~out_stall;
	assign sample_out = data_q[head_q];
	assign level     = level_q;

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[tail_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == OUTQ_LAST) ? 2'd0 : tail_q + 2'd1;
			end
			if (pop) begin
				head_q <= (head_q == OUTQ_LAST) ? 2'd0 : head_q + 2'd1;
			end
			if (push && !pop) begin
				level_q <= level_q + OUTQ_LEVEL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - OUTQ_LEVEL_W'(1);
			end
		end
	end

endmodule

@@ tb/tb_zero_crossing_chunk_pitch_squeezer_top.sv @@
// Self-checking testbench for the zero-crossing chunk pitch squeezer top level.
// Drives samples, register writes and output stalls, and checks every output sample
// against a built-in predictor. Depends on zccps_pkg and the block's RTL only.
module tb_zero_crossing_chunk_pitch_squeezer_top import zccps_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN     = 4096;
	localparam int SAMPLE_W    = 24;
	localparam int FRAC_W      = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 64;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample_in;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SAMPLE_W-1:0]   sample_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor state: the chunk store, its pointers and the register copies.
	logic [SAMPLE_W-1:0]    chunk[MAX_LEN];
	logic [11:0]            wr_idx;
	int unsigned            read_pos;
	logic [SAMPLE_W-1:0]    prev_sample;
	logic [7:0]             cross_cnt;
	logic [LEN_CFG_W-1:0]   len_reg;
	logic [RATIO_CFG_W-1:0] ratio_reg;
	logic [CROSS_CFG_W-1:0] cross_reg;

	logic [SAMPLE_W-1:0] expected_samples[$];
	logic [SAMPLE_W-1:0] want;
	int                  mismatches = 0;
	int                  send_idle_pct = 0;
	int                  stall_pct = 0;
	int                  hold_req = 0;
	int                  hold_ack = 0;
	int                  hold_left = 0;
	int                  quiet_cycles = 0;
	logic                wave_neg = 1'b0;
	int                  run_left = 0;

	zero_crossing_chunk_pitch_squeezer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Advance the predictor by one sample and return the sample it reads back.
	function automatic logic [SAMPLE_W-1:0] squeeze_step(input logic [SAMPLE_W-1:0] s);
		int unsigned         len;
		int unsigned         ratio;
		int unsigned         ridx;
		int unsigned         nxt;
		logic                fresh;
		logic [SAMPLE_W-1:0] y;
		len = len_reg;
		if (len < 2) len = 2;
		if (len > MAX_LEN) len = MAX_LEN;
		ratio = ratio_reg;
		if (ratio < (1 << FRAC_W)) ratio = 1 << FRAC_W;
		if (ratio > (len << FRAC_W)) ratio = len << FRAC_W;
		// Read side: output the stored sample until the read index passes the chunk.
		y = '0;
		ridx = read_pos >> FRAC_W;
		if (ridx < len) begin
			y = chunk[ridx % MAX_LEN];
			read_pos = read_pos + ratio;
		end
		// Write side: a full chunk or enough rising crossings start a new chunk.
		nxt = wr_idx + 1;
		fresh = 1'b0;
		if (nxt >= len) begin
			fresh = 1'b1;
		end else if (prev_sample[SAMPLE_W-1] && !s[SAMPLE_W-1]) begin
			cross_cnt = cross_cnt + 8'd1;
			if (cross_cnt >= cross_reg) fresh = 1'b1;
		end
		if (fresh) begin
			nxt = 0;
			read_pos = 0;
			cross_cnt = '0;
		end
		wr_idx = nxt[11:0];
		chunk[wr_idx] = s;
		prev_sample = s;
		return y;
	endfunction

	// Next sample of a square-ish wave with random runs, plus some noise.
	function automatic logic [SAMPLE_W-1:0] next_wave_sample(input int run_max);
		logic [SAMPLE_W-1:0] s;
		if (run_left == 0) begin
			wave_neg = !wave_neg;
			run_left = $urandom_range(run_max, 1);
		end
		run_left--;
		s = SAMPLE_W'($urandom);
		s[SAMPLE_W-1] = wave_neg;
		if ($urandom_range(99) < 4) s = wave_neg ? 24'h800000 : 24'h000000;
		if ($urandom_range(99) < 10) s = SAMPLE_W'($urandom);
		return s;
	endfunction

	// Offer one item, idling first at random, and record its prediction once taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		do @(posedge clk); while (in_stall);
		expected_samples.push_back(squeeze_step(s));
	endtask

	// Stop sending and wait until every expected sample has come out.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BUFFER_LENGTH: len_reg = val[LEN_CFG_W-1:0];
			REG_PITCH_RATIO:   ratio_reg = val[RATIO_CFG_W-1:0];
			REG_CROSSINGS:     cross_reg = val[CROSS_CFG_W-1:0];
			default: ;
		endcase
	endtask

	// Registers change only once the block has gone idle.
	task automatic set_registers(input int len, input int ratio, input int crossings);
		settle();
		write_reg(REG_BUFFER_LENGTH, CFG_DATA_W'(len));
		write_reg(REG_PITCH_RATIO, CFG_DATA_W'(ratio));
		write_reg(REG_CROSSINGS, CFG_DATA_W'(crossings));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reset register values, sample extremes and a rising crossing that ends a chunk.
	task automatic test_reset_state();
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h000001);
		send_sample(24'h400000);
		send_sample(24'hC00000);
	endtask

	// A length lowered below the current write index must start a new chunk.
	task automatic test_length_lowered();
		set_registers(MAX_LEN, 256, 255);
		repeat (10) send_sample({1'b0, 23'($urandom)});
		set_registers(4, 256, 255);
		repeat (3) send_sample({1'b0, 23'($urandom)});
	endtask

	// With zero crossings per chunk, every rising crossing starts a new chunk.
	task automatic test_every_crossing();
		set_registers(16, 0, 0);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h7FFFFF);
		send_sample(24'h800001);
		send_sample(24'h000000);
	endtask

	// A long output hold fills the block, then the sender waits for a full drain.
	task automatic test_backpressure();
		set_registers(64, 640, 255);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req <= hold_req + 1;
		repeat (24) send_sample(next_wave_sample(8));
		settle();
		repeat (8) send_sample(next_wave_sample(8));
	endtask

	// Random waveforms over many register settings and idling patterns.
	task automatic test_random_traffic();
		int len;
		int ratio;
		int crossings;
		int run_max;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin len = 2;    ratio = 256;     crossings = 0;   end
				1: begin len = 0;    ratio = 0;       crossings = 1;   end
				2: begin len = 1;    ratio = 2097151; crossings = 255; end
				3: begin len = 8191; ratio = 255;     crossings = 2;   end
				4: begin len = 4096; ratio = 1048576; crossings = 1;   end
				5: begin len = 3;    ratio = 257;     crossings = 0;   end
				6: begin len = 17;   ratio = 384;     crossings = 128; end
				7: begin len = 64;   ratio = 512;     crossings = 3;   end
				default: begin
					len = ($urandom_range(9) == 0) ? $urandom_range(8191, 0)
						: $urandom_range(80, 2);
					ratio = ($urandom_range(9) == 0) ? $urandom_range(2097151, 0)
						: $urandom_range(2048, 0);
					crossings = ($urandom_range(4) == 0) ? $urandom_range(255, 0)
						: $urandom_range(4, 0);
				end
			endcase
			set_registers(len, ratio, crossings);
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 33; stall_pct = 33; end
			endcase
			run_max = (p % 3 == 0) ? 1 : ((p % 3 == 1) ? 8 : 64);
			repeat (PHASE_ITEMS) send_sample(next_wave_sample(run_max));
		end
	endtask

	// Output stall: a long hold when requested, otherwise random.
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each output item with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual sample_out %h",
					$time, sample_out);
				mismatches++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want) begin
					$display("%0t: sample_out expected %h actual %h", $time, want, sample_out);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
			|| !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BUFFER_LENGTH;
		cfg_data = '0;
		foreach (chunk[i]) chunk[i] = '0;
		wr_idx = '0;
		read_pos = 0;
		prev_sample = '0;
		cross_cnt = '0;
		len_reg = LEN_RESET;
		ratio_reg = RATIO_RESET;
		cross_reg = CROSS_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_length_lowered();
		test_every_crossing();
		test_backpressure();
		test_random_traffic();
		settle();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ zero_crossing_chunk_pitch_squeezer_top.f @@
+incdir+rtl
rtl/zccps_pkg.sv
rtl/zccps_store.sv
rtl/zccps_ctrl.sv
rtl/zccps_outq.sv
rtl/zero_crossing_chunk_pitch_squeezer_top.sv
tb/tb_zero_crossing_chunk_pitch_squeezer_top.sv
